@@ rtl/edd_pkg.sv @@
// ----------------------------------------------------------------------------
// edd_pkg
// Shared types, widths and helpers for the error diffusion ditherer.
// ----------------------------------------------------------------------------
package edd_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int FRAC_BITS = 8;
	localparam int PIXEL_W   = 8;
	localparam int LW_W      = 12;
	localparam int LW_RESET  = 640;
	localparam int WIDTH_W   = $clog2(MAX_WIDTH + 1);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam int ERR_BITS  = 20;
	localparam int ERR_MAX   = (1 << (ERR_BITS - 1)) - 1;
	localparam int ERR_MIN   = -(1 << (ERR_BITS - 1));

	// corrected value: pixel in fixed point plus two saturated errors
	localparam int PIX_FX_W  = PIXEL_W + FRAC_BITS + 1;
	localparam int VAL_W     = ((PIX_FX_W > ERR_BITS) ? PIX_FX_W : ERR_BITS) + 2;
	// headroom for the x7 share and the partial sums
	localparam int CALC_W    = VAL_W + 4;

	// register indexes, register i sits at byte address 4*i
	typedef enum logic {
		REG_LINE_WIDTH = 1'b0,
		REG_INVERT     = 1'b1
	} reg_idx_t;

	typedef logic signed [ERR_BITS-1:0] err_t;
	typedef logic signed [CALC_W-1:0]   calc_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               frame_start;
	} in_t;

	typedef struct packed {
		logic bit_out;
		logic row_last;
	} out_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] width;
		logic               invert;
	} cfg_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               frame_start;
		logic               first_row;
		logic               last;
		logic [COL_W-1:0]   col;
	} stage_t;

	function automatic err_t sat_err(input calc_t v);
		err_t r;
		if (v > CALC_W'(ERR_MAX)) begin
			r = ERR_BITS'(ERR_MAX);
		end else if (v < CALC_W'(ERR_MIN)) begin
			r = ERR_BITS'(ERR_MIN);
		end else begin
			r = ERR_BITS'(v);
		end
		return r;
	endfunction

endpackage

@@ rtl/edd_ram.sv @@
// ----------------------------------------------------------------------------
// edd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module edd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/edd_cfg.sv @@
// ----------------------------------------------------------------------------
// edd_cfg
// APB register file: line width and output inversion.
// ----------------------------------------------------------------------------
module edd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [edd_pkg::PADDR_W-1:0] paddr,
	input  logic [edd_pkg::PDATA_W-1:0] pwdata,
	output logic [edd_pkg::PDATA_W-1:0] prdata,
	output logic                       pready,
	output edd_pkg::cfg_t              cfg
);

	logic [edd_pkg::LW_W-1:0] line_width_q;
	logic                     invert_q;
	logic                     wr;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= edd_pkg::LW_W'(edd_pkg::LW_RESET);
			invert_q     <= 1'b0;
		end else if (wr) begin
			unique case (paddr[2])
				edd_pkg::REG_LINE_WIDTH: line_width_q <= pwdata[edd_pkg::LW_W-1:0];
				edd_pkg::REG_INVERT:     invert_q     <= pwdata[0];
				default:                 invert_q     <= invert_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			edd_pkg::REG_LINE_WIDTH: prdata = edd_pkg::PDATA_W'(line_width_q);
			edd_pkg::REG_INVERT:     prdata = edd_pkg::PDATA_W'(invert_q);
			default:                 prdata = '0;
		endcase
	end

	// zero acts as one, oversize widths stop at the line buffer depth
	always_comb begin
		if (line_width_q == '0) begin
			cfg.width = edd_pkg::WIDTH_W'(1);
		end else if (32'(line_width_q) > 32'(edd_pkg::MAX_WIDTH)) begin
			cfg.width = edd_pkg::WIDTH_W'(edd_pkg::MAX_WIDTH);
		end else begin
			cfg.width = edd_pkg::WIDTH_W'(line_width_q);
		end
		cfg.invert = invert_q;
	end

endmodule

@@ rtl/edd_sched.sv @@
// ----------------------------------------------------------------------------
// edd_sched
// Input register stage: column and first-row tracking, line buffer address.
// ----------------------------------------------------------------------------
module edd_sched (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        fire,
	input  edd_pkg::in_t                in_data,
	input  logic [edd_pkg::WIDTH_W-1:0] width,
	output logic                        valid_s1,
	output edd_pkg::stage_t             stage_s1,
	output logic [edd_pkg::COL_W-1:0]   rd_col
);

	logic [edd_pkg::COL_W-1:0] column_q;
	logic                      first_row_q;
	logic [edd_pkg::COL_W-1:0] col_raw;
	logic [edd_pkg::COL_W-1:0] col;
	logic                      last;
	logic                      first;

	always_comb begin
		col_raw = in_data.frame_start ? '0 : column_q;
		// a column past a shrunk width is the row's last
		if (edd_pkg::WIDTH_W'(col_raw) >= width) begin
			col = edd_pkg::COL_W'(width - edd_pkg::WIDTH_W'(1));
		end else begin
			col = col_raw;
		end
		last  = (edd_pkg::WIDTH_W'(col) + edd_pkg::WIDTH_W'(1)) >= width;
		first = in_data.frame_start | first_row_q;
	end

	assign rd_col = col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
			valid_s1    <= 1'b0;
		end else begin
			if (accept) begin
				column_q    <= last ? '0 : col + edd_pkg::COL_W'(1);
				first_row_q <= last ? 1'b0 : first;
				valid_s1    <= 1'b1;
			end else if (fire) begin
				valid_s1    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.pixel       <= in_data.pixel;
			stage_s1.frame_start <= in_data.frame_start;
			stage_s1.first_row   <= first;
			stage_s1.last        <= last;
			stage_s1.col         <= col;
		end
	end

endmodule

@@ rtl/edd_diffuse.sv @@
// ----------------------------------------------------------------------------
// edd_diffuse
// Threshold and error split for the item in the input register, plus the
// diffusion state and the line buffer write port.
// ----------------------------------------------------------------------------
module edd_diffuse (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      fire,
	input  edd_pkg::stage_t           stage_s1,
	input  logic [edd_pkg::COL_W-1:0] rd_col,
	input  edd_pkg::err_t             ram_rdata,
	output logic                      ram_we,
	output logic [edd_pkg::COL_W-1:0] ram_waddr,
	output edd_pkg::err_t             ram_wdata,
	output logic                      on_bit
);

	localparam edd_pkg::calc_t THRESH = edd_pkg::CALC_W'(128 << edd_pkg::FRAC_BITS);
	localparam edd_pkg::calc_t FULL   = edd_pkg::CALC_W'(255 << edd_pkg::FRAC_BITS);

	edd_pkg::err_t carry_q;
	edd_pkg::err_t bl_q;
	edd_pkg::err_t b_q;

	// entry finished at the end of a row, written when the port is free
	logic                      pend_valid_q;
	logic [edd_pkg::COL_W-1:0] pend_col_q;
	edd_pkg::err_t             pend_data_q;

	logic          fwd_hit_s1;
	edd_pkg::err_t fwd_data_s1;

	edd_pkg::err_t  cr, bl, b, above;
	edd_pkg::calc_t pix_fx, val, err;
	edd_pkg::calc_t p7, p3, p5, s7, s3, s5, s1;
	edd_pkg::err_t  d_bl, new_bl, new_b, new_carry;

	logic                      direct_we;
	logic [edd_pkg::COL_W-1:0] direct_col;
	logic                      set_pend;
	logic                      drain;
	logic                      fwd_hit;
	edd_pkg::err_t             fwd_data;

	always_comb begin
		cr    = stage_s1.frame_start ? '0 : carry_q;
		bl    = stage_s1.frame_start ? '0 : bl_q;
		b     = stage_s1.frame_start ? '0 : b_q;
		above = stage_s1.first_row ? '0 : (fwd_hit_s1 ? fwd_data_s1 : ram_rdata);

		pix_fx = edd_pkg::CALC_W'($signed({1'b0, stage_s1.pixel,
			{edd_pkg::FRAC_BITS{1'b0}}}));
		val    = pix_fx + edd_pkg::CALC_W'(cr) + edd_pkg::CALC_W'(above);
		on_bit = val >= THRESH;
		err    = on_bit ? val - FULL : val;

		p7 = (err <<< 3) - err;
		p3 = (err <<< 1) + err;
		p5 = (err <<< 2) + err;
		// floor shares
		s7 = p7 >>> 4;
		s3 = p3 >>> 4;
		s5 = p5 >>> 4;
		s1 = err >>> 4;

		d_bl      = edd_pkg::sat_err(edd_pkg::CALC_W'(bl) + s3);
		new_bl    = edd_pkg::sat_err(edd_pkg::CALC_W'(b) + s5);
		new_b     = edd_pkg::sat_err(s1);
		new_carry = edd_pkg::sat_err(s7);
	end

	always_comb begin
		direct_we  = fire & (stage_s1.col != '0);
		direct_col = stage_s1.col - edd_pkg::COL_W'(1);
		set_pend   = fire & stage_s1.last;
		drain      = pend_valid_q & ~direct_we;

		ram_we    = direct_we | drain;
		ram_waddr = direct_we ? direct_col : pend_col_q;
		ram_wdata = direct_we ? d_bl : pend_data_q;

		// the RAM read returns old data, so catch writes landing with or after it
		if (set_pend && stage_s1.col == rd_col) begin
			fwd_hit  = 1'b1;
			fwd_data = new_bl;
		end else if (direct_we && direct_col == rd_col) begin
			fwd_hit  = 1'b1;
			fwd_data = d_bl;
		end else if (drain && pend_col_q == rd_col) begin
			fwd_hit  = 1'b1;
			fwd_data = pend_data_q;
		end else begin
			fwd_hit  = 1'b0;
			fwd_data = pend_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q      <= '0;
			bl_q         <= '0;
			b_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				carry_q <= stage_s1.last ? '0 : new_carry;
				bl_q    <= stage_s1.last ? '0 : new_bl;
				b_q     <= stage_s1.last ? '0 : new_b;
			end
			if (set_pend) begin
				pend_valid_q <= 1'b1;
			end else if (drain) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (set_pend) begin
			pend_col_q  <= stage_s1.col;
			pend_data_q <= new_bl;
		end
		if (accept) begin
			fwd_hit_s1  <= fwd_hit;
			fwd_data_s1 <= fwd_data;
		end
	end

`ifndef SYNTH
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(direct_we && pend_valid_q))
		else $error("row-end entry still pending when a direct write arrives");

	a_pend_set: assert property (@(posedge clk) disable iff (!arst_n)
		fire && stage_s1.last |=> pend_valid_q)
		else $error("row-end entry not held after the last item of a row");

	a_fwd_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept && set_pend && (stage_s1.col == rd_col) |=> fwd_hit_s1)
		else $error("read of the row-end entry missed its forward");
`endif

endmodule

@@ rtl/error_diffusion_dither.sv @@
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Floyd-Steinberg error diffusion of 8-bit grey pixels to one bit each.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_data  (pixel, frame_start)
//   out      output     out_valid/out_stall out_data (bit_out, row_last)
//   cfg      input      APB write/read      line_width @0x0, invert @0x4
//
// One item per clock sustained while the output is not stalled; an accepted
// item passes the input register, then the output register. The row error
// buffer is one RAM with one write and one registered read port; a read-ahead
// plus forwarding from the pending writes keeps the neighbor-to-neighbor loop
// free of stalls. Reset clears the diffusion state and the row counter; the row
// buffer needs no clearing pass since the first row of a frame never reads it.
// With the output stalled the item register holds, and in_stall rises only
// when it is full.
// ----------------------------------------------------------------------------
module error_diffusion_dither (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  edd_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output edd_pkg::out_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [edd_pkg::PADDR_W-1:0] paddr,
	input  logic [edd_pkg::PDATA_W-1:0] pwdata,
	output logic [edd_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	edd_pkg::cfg_t             cfg;
	edd_pkg::stage_t           stage_s1;
	logic                      valid_s1;
	logic [edd_pkg::COL_W-1:0] rd_col;
	edd_pkg::err_t             ram_rdata;
	logic                      ram_we;
	logic [edd_pkg::COL_W-1:0] ram_waddr;
	edd_pkg::err_t             ram_wdata;
	logic                      on_bit;
	logic                      adv;
	logic                      accept;
	logic                      fire;
	logic                      out_valid_q;
	edd_pkg::out_t             out_data_q;

	assign adv      = ~out_valid_q | ~out_stall;
	assign in_stall = valid_s1 & ~adv;
	assign accept   = in_valid & ~in_stall;
	assign fire     = valid_s1 & adv;

	edd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	edd_sched u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.fire     (fire),
		.in_data  (in_data),
		.width    (cfg.width),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.rd_col   (rd_col)
	);

	edd_ram #(
		.WIDTH (edd_pkg::ERR_BITS),
		.DEPTH (edd_pkg::MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (rd_col),
		.rdata (ram_rdata)
	);

	edd_diffuse u_diffuse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.fire      (fire),
		.stage_s1  (stage_s1),
		.rd_col    (rd_col),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.on_bit    (on_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.bit_out  <= on_bit ^ cfg.invert;
			out_data_q.row_last <= stage_s1.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ verif/error_diffusion_dither_test.sv @@
// ----------------------------------------------------------------------------
// error_diffusion_dither_test
// Self-checking bench for the Floyd-Steinberg ditherer. A short stimulus table
// covers threshold edges, inversion, width clamping and a width cut mid-row.
// Random phases follow, each with its own line width and invert setting.
// Every accepted pixel runs through a local error-diffusion model, and each
// output bit is compared in order against it, or against the table entry for
// typed rows, under random input gaps and random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module error_diffusion_dither_test;

	localparam int RANDOM_PIXELS  = 1000;
	localparam int LONG_PIXELS    = 400;
	localparam int DRAIN_CYCLES   = 8;
	localparam int IDLE_LIMIT     = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int MAX_REPORTS    = 20;

	typedef logic signed [edd_pkg::ERR_BITS-1:0] serr_t;

	typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH, ROW_INVERT} row_kind_t;

	typedef struct packed {
		row_kind_t     kind;
		logic [11:0]   value;
		logic          fs;
		logic          typed;
		edd_pkg::out_t want;
	} drow_t;

	localparam int DIR_N = 30;
	localparam drow_t DIR_TAB [DIR_N] = '{
		'{ROW_PIXEL,  12'd0,    1'b1, 1'b1, 2'b00},
		'{ROW_PIXEL,  12'd255,  1'b1, 1'b1, 2'b10},
		'{ROW_PIXEL,  12'd128,  1'b1, 1'b1, 2'b10},
		'{ROW_PIXEL,  12'd127,  1'b1, 1'b1, 2'b00},
		// width 0 acts as 1, and the current column is already past it
		'{ROW_WIDTH,  12'd0,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd200,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd50,   1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd255,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd0,    1'b0, 1'b0, 2'b00},
		'{ROW_INVERT, 12'd1,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd0,    1'b1, 1'b1, 2'b11},
		'{ROW_PIXEL,  12'd255,  1'b1, 1'b1, 2'b01},
		'{ROW_INVERT, 12'd0,    1'b0, 1'b0, 2'b00},
		'{ROW_WIDTH,  12'd3,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd100,  1'b1, 1'b1, 2'b00},
		'{ROW_PIXEL,  12'd100,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd100,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd100,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd255,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd0,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd0,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd200,  1'b0, 1'b0, 2'b00},
		'{ROW_WIDTH,  12'd2,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd30,   1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd220,  1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd128,  1'b0, 1'b0, 2'b00},
		// widths above the maximum clamp
		'{ROW_WIDTH,  12'd4095, 1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd255,  1'b1, 1'b1, 2'b10},
		'{ROW_PIXEL,  12'd0,    1'b0, 1'b0, 2'b00},
		'{ROW_PIXEL,  12'd254,  1'b0, 1'b0, 2'b00}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	edd_pkg::in_t                 in_data;
	logic                         out_valid;
	logic                         out_stall;
	edd_pkg::out_t                out_data;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [edd_pkg::PADDR_W-1:0]  paddr;
	logic [edd_pkg::PDATA_W-1:0]  pwdata;
	logic [edd_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;

	// local model state
	serr_t       err_row [edd_pkg::MAX_WIDTH];
	bit          row_written [edd_pkg::MAX_WIDTH];
	serr_t       carry_err;
	serr_t       bl_err;
	serr_t       below_err;
	int          col_pos;
	bit          in_first_row;
	logic [11:0] cfg_width;
	logic        cfg_invert;

	edd_pkg::out_t bits_due [$];
	bit            typed_now;
	edd_pkg::out_t typed_val;

	int errors;
	int pixels_in;
	int bits_out;
	int phases;
	int burst_left;
	int idle_cycles;
	int hold_reqs;
	int hold_done;
	int hold_left;
	int stall_mode;
	int mode_left;

	error_diffusion_dither DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_width();
		int w;
		w = int'(cfg_width);
		if (w == 0) w = 1;
		if (w > edd_pkg::MAX_WIDTH) w = edd_pkg::MAX_WIDTH;
		return w;
	endfunction

	function automatic serr_t clamp_err(input longint v);
		serr_t r;
		if (v > longint'(edd_pkg::ERR_MAX)) r = serr_t'(edd_pkg::ERR_MAX);
		else if (v < longint'(edd_pkg::ERR_MIN)) r = serr_t'(edd_pkg::ERR_MIN);
		else r = serr_t'(v);
		return r;
	endfunction

	function automatic edd_pkg::out_t diffuse_pixel(input edd_pkg::in_t it);
		int            w;
		int            c;
		longint        one;
		longint        above;
		longint        val;
		longint        e;
		serr_t         nbl;
		serr_t         nb;
		logic          on;
		logic          last;
		edd_pkg::out_t r;
		w = eff_width();
		one = longint'(1) << edd_pkg::FRAC_BITS;
		if (it.frame_start) begin
			col_pos      = 0;
			in_first_row = 1'b1;
			carry_err    = '0;
			bl_err       = '0;
			below_err    = '0;
		end
		c = (col_pos >= w) ? w - 1 : col_pos;
		above = in_first_row ? 64'sd0 : longint'(err_row[c]);
		val = longint'(it.pixel) * one + longint'(carry_err) + above;
		on = (val >= 128 * one);
		e = val - (on ? 255 * one : 64'sd0);
		if (c > 0) begin
			err_row[c-1]     = clamp_err(longint'(bl_err) + ((e * 3) >>> 4));
			row_written[c-1] = 1'b1;
		end
		nbl       = clamp_err(longint'(below_err) + ((e * 5) >>> 4));
		nb        = clamp_err(e >>> 4);
		carry_err = clamp_err((e * 7) >>> 4);
		last = (c + 1 >= w);
		if (last) begin
			err_row[c]     = nbl;
			row_written[c] = 1'b1;
			carry_err      = '0;
			bl_err         = '0;
			below_err      = '0;
			col_pos        = 0;
			in_first_row   = 1'b0;
		end else begin
			bl_err    = nbl;
			below_err = nb;
			col_pos   = c + 1;
		end
		r.bit_out  = on ^ cfg_invert;
		r.row_last = last;
		return r;
	endfunction

	function automatic logic [7:0] pick_pixel();
		logic [7:0] p;
		case ($urandom_range(0, 9))
			0: p = 8'd0;
			1: p = 8'd255;
			2: p = 8'($urandom_range(120, 135));
			default: p = 8'($urandom_range(0, 255));
		endcase
		return p;
	endfunction

	// prediction and output checking
	always @(posedge clk) begin
		edd_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				bits_out++;
				if (bits_due.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected output %b/%b", $time,
							out_data.bit_out, out_data.row_last);
				end else begin
					want = bits_due.pop_front();
					if (out_data.bit_out !== want.bit_out) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: bit_out expected %b actual %b", $time,
								want.bit_out, out_data.bit_out);
					end
					if (out_data.row_last !== want.row_last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: row_last expected %b actual %b", $time,
								want.row_last, out_data.row_last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				pixels_in++;
				want = diffuse_pixel(in_data);
				if (typed_now) want = typed_val;
				bits_due.push_back(want);
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("error_diffusion_dither regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// receiver: stall pattern changes mode now and then, plus one long hold
	initial begin
		forever begin
			@(negedge clk);
			if (hold_reqs != hold_done) begin
				hold_done = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left  = $urandom_range(10, 60);
				end
				mode_left--;
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	task automatic send_pixel(input logic [7:0] pix, input logic fs, input logic typed,
			input edd_pkg::out_t want);
		int           gap;
		int           c;
		edd_pkg::in_t it;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		// never read a line entry that has not been written yet
		c = (col_pos >= eff_width()) ? eff_width() - 1 : col_pos;
		if (!fs && !in_first_row && !row_written[c]) fs = 1'b1;
		it.pixel       = pix;
		it.frame_start = fs;
		in_valid  <= 1'b1;
		in_data   <= it;
		typed_now <= typed;
		typed_val <= want;
		do @(posedge clk); while (!(in_valid && !in_stall));
		burst_left--;
	endtask

	task automatic reg_check(input edd_pkg::reg_idx_t idx,
			input logic [edd_pkg::PDATA_W-1:0] want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= edd_pkg::PADDR_W'(int'(idx) * 4);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: register %0d expected %0d actual %0d", $time, idx,
					want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic cfg_write(input edd_pkg::reg_idx_t idx, input logic [11:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (bits_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= edd_pkg::PADDR_W'(int'(idx) * 4);
		pwdata  <= edd_pkg::PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == edd_pkg::REG_LINE_WIDTH) cfg_width = value;
		else cfg_invert = value[0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == edd_pkg::REG_LINE_WIDTH) reg_check(idx, edd_pkg::PDATA_W'(value));
		else reg_check(idx, edd_pkg::PDATA_W'(value[0]));
	endtask

	initial begin
		int          rnd_pixels;
		int          n;
		logic [11:0] w;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		typed_now = 1'b0;
		typed_val = '0;
		errors      = 0;
		pixels_in   = 0;
		bits_out    = 0;
		phases      = 0;
		burst_left  = 0;
		idle_cycles = 0;
		hold_reqs   = 0;
		hold_done   = 0;
		hold_left   = 0;
		stall_mode  = 0;
		mode_left   = 0;
		rnd_pixels  = 0;
		foreach (err_row[i]) begin
			err_row[i]     = '0;
			row_written[i] = 1'b0;
		end
		carry_err    = '0;
		bl_err       = '0;
		below_err    = '0;
		col_pos      = 0;
		in_first_row = 1'b1;
		cfg_width    = 12'(edd_pkg::LW_RESET);
		cfg_invert   = 1'b0;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		reg_check(edd_pkg::REG_LINE_WIDTH, edd_pkg::PDATA_W'(edd_pkg::LW_RESET));
		reg_check(edd_pkg::REG_INVERT, '0);

		for (int i = 0; i < DIR_N; i++) begin
			case (DIR_TAB[i].kind)
				ROW_PIXEL: send_pixel(DIR_TAB[i].value[7:0], DIR_TAB[i].fs,
					DIR_TAB[i].typed, DIR_TAB[i].want);
				ROW_WIDTH: cfg_write(edd_pkg::REG_LINE_WIDTH, DIR_TAB[i].value);
				default: cfg_write(edd_pkg::REG_INVERT, DIR_TAB[i].value);
			endcase
		end

		// long row: one frame across the maximum and the clamped width
		cfg_write(edd_pkg::REG_INVERT, 12'($urandom_range(0, 1)));
		cfg_write(edd_pkg::REG_LINE_WIDTH, 12'(edd_pkg::MAX_WIDTH));
		for (int i = 0; i < LONG_PIXELS; i++) send_pixel(pick_pixel(), i == 0, 1'b0, '0);
		cfg_write(edd_pkg::REG_LINE_WIDTH, 12'd4095);
		for (int i = 0; i < LONG_PIXELS; i++) send_pixel(pick_pixel(), 1'b0, 1'b0, '0);

		while (rnd_pixels < RANDOM_PIXELS) begin
			case ($urandom_range(0, 19))
				0: w = 12'd0;
				1: w = 12'd1;
				2: w = 12'd2;
				3: w = 12'($urandom_range(edd_pkg::MAX_WIDTH + 1, 4095));
				4, 5: w = 12'($urandom_range(13, 90));
				default: w = 12'($urandom_range(1, 12));
			endcase
			cfg_write(edd_pkg::REG_LINE_WIDTH, w);
			cfg_write(edd_pkg::REG_INVERT, 12'($urandom_range(0, 1)));
			phases++;
			n = $urandom_range(20, 120);
			if (phases == 3) begin
				n = 200;
				hold_reqs++;
			end
			for (int i = 0; i < n; i++) begin
				send_pixel(pick_pixel(),
					(i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0),
					1'b0, '0);
				rnd_pixels++;
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (bits_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d pixels through %0d random phases plus table and long rows,",
			pixels_in, phases);
		$display("checked %0d output bits with %0d mismatches", bits_out, errors);
		if (errors == 0) begin
			$display("error_diffusion_dither regression: pass");
		end else begin
			$display("error_diffusion_dither regression: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/edd_pkg.sv
rtl/edd_ram.sv
rtl/edd_cfg.sv
rtl/edd_sched.sv
rtl/edd_diffuse.sv
rtl/error_diffusion_dither.sv
verif/error_diffusion_dither_test.sv
